/* rtl/core/plp_pkg.sv */
// Package for the polyline point locator.
// Word types for the item, result, queue and register channels, codes and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plp_pkg;

  // command codes of an item word
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_DIST    = 2'd2;
  localparam logic [1:0] CMD_NEAREST = 2'd3;

  // operation codes carried through the queue
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_DIST    = 2'd2;
  localparam logic [1:0] OP_NEAREST = 2'd3;

  // reply kinds
  localparam logic REPLY_DIST    = 1'b0;
  localparam logic REPLY_NEAREST = 1'b1;

  // register indexes and reset values
  localparam logic REG_MUPP   = 1'b0;
  localparam logic REG_RADIUS = 1'b1;
  localparam logic [23:0] MUPP_RESET   = 24'd256;
  localparam logic [7:0]  RADIUS_RESET = 8'd30;

  // queue depth between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [31:0]        along_distance;
  } item_t;

  typedef struct packed {
    logic               reply_kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         segment_index;
  } result_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        along;
  } op_t;

  typedef struct packed {
    logic [23:0] map_units_per_pixel;
    logic [7:0]  pick_radius_pixels;
  } cfg_t;

  // magnitude of a 33-bit two's complement value
  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/plp_front.sv */
// Front part: takes item words and classifies them into queue operations.
// Depends on plp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plp_front
  import plp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       push,
  output op_t        push_op,
  input  wire logic  queue_full
);

  logic  slot_valid;
  op_t   slot;
  op_t   op_dec;
  logic  take;

  // decode the command into an operation code
  always_comb begin
    op_dec.x     = item.coord_x;
    op_dec.y     = item.coord_y;
    op_dec.along = item.along_distance;
    unique case (item.command)
      CMD_CLEAR:   op_dec.kind = OP_CLEAR;
      CMD_APPEND:  op_dec.kind = OP_APPEND;
      CMD_DIST:    op_dec.kind = OP_DIST;
      CMD_NEAREST: op_dec.kind = OP_NEAREST;
      default:     op_dec.kind = OP_CLEAR;
    endcase
  end

  assign push       = slot_valid && !queue_full;
  assign push_op    = slot;
  assign item_stall = slot_valid && queue_full;
  assign take       = item_valid && !item_stall;

  // one-word holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (take) begin
      slot_valid <= 1'b1;
    end else if (push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot <= op_dec;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/plp_queue.sv */
// Short operation queue between the front and back parts.
// Depends on plp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plp_queue
  import plp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output op_t       head
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t          entries [QUEUE_DEPTH];
  logic [QAW:0] wr_ptr;
  logic [QAW:0] rd_ptr;

  assign not_empty = (wr_ptr != rd_ptr);
  assign full      = (wr_ptr[QAW] != rd_ptr[QAW]) && (wr_ptr[QAW-1:0] == rd_ptr[QAW-1:0]);
  assign head      = entries[rd_ptr[QAW-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr[QAW-1:0]] <= push_op;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/plp_back.sv */
// Back part: vertex store, segment walk sequencer, shared multiplier,
// bit-serial square root and divider, result register. Depends on plp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plp_back
  import plp_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  input  wire op_t     q_op,
  output logic         q_pop,
  input  wire cfg_t    cfg,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_LOOP = 5'd1;
  localparam logic [4:0] ST_DIFF = 5'd2;
  localparam logic [4:0] ST_LAST = 5'd3;
  localparam logic [4:0] D_M1    = 5'd4;
  localparam logic [4:0] D_M2    = 5'd5;
  localparam logic [4:0] D_M3    = 5'd6;
  localparam logic [4:0] D_SQ    = 5'd7;
  localparam logic [4:0] D_CMP   = 5'd8;
  localparam logic [4:0] D_IM    = 5'd9;
  localparam logic [4:0] D_DL    = 5'd10;
  localparam logic [4:0] DV      = 5'd11;
  localparam logic [4:0] DV_END  = 5'd12;
  localparam logic [4:0] C_M1    = 5'd13;
  localparam logic [4:0] C_M2    = 5'd14;
  localparam logic [4:0] C_M3    = 5'd15;
  localparam logic [4:0] C_M4    = 5'd16;
  localparam logic [4:0] C_M5    = 5'd17;
  localparam logic [4:0] C_CLS   = 5'd18;
  localparam logic [4:0] C_IM1   = 5'd19;
  localparam logic [4:0] C_IM2   = 5'd20;
  localparam logic [4:0] C_IM3   = 5'd21;
  localparam logic [4:0] C_D1    = 5'd22;
  localparam logic [4:0] C_D2    = 5'd23;
  localparam logic [4:0] C_D3    = 5'd24;
  localparam logic [4:0] C_L0    = 5'd25;
  localparam logic [4:0] C_L1    = 5'd26;
  localparam logic [4:0] C_L2    = 5'd27;
  localparam logic [4:0] ST_OUT  = 5'd28;

  logic [4:0]    state;
  op_t           cur;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW:0]   i_plus1;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] idx_b;

  // vertex store
  logic [31:0] mem_x [MAX_VERTICES];
  logic [31:0] mem_y [MAX_VERTICES];
  logic [31:0] ax, ay, bx, by;
  logic        wr_en;

  // datapath registers
  logic [32:0] dx, dy, wx, wy;
  logic [31:0] r;
  logic [32:0] root;
  logic [34:0] sq_rem;
  logic [65:0] prod;
  logic        psign;
  logic [98:0] acc;
  logic [66:0] num;
  logic [65:0] den;
  logic [31:0] qx, qy;
  logic [65:0] best;
  logic        have;
  logic [31:0] bqx, bqy;
  logic [CW-1:0] bi;
  logic        axis;
  logic [5:0]  iter;
  result_t     res;

  // combinational helpers
  logic [32:0] mul_a, mul_b;
  logic        mul_sign;
  logic [36:0] sq_t, sq_trial;
  logic [66:0] dv_t, dv_den;
  logic        dv_ge;
  logic [65:0] dv_rem;
  logic [32:0] s_axis;
  logic [31:0] base_axis;
  logic [31:0] pt;
  logic [66:0] num_add;
  logic [65:0] d2;
  logic        out_free;

  assign i_plus1  = {1'b0, i} + 1'b1;
  assign idx_a    = i[AW-1:0];
  assign idx_b    = i_plus1[AW-1:0];
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign wr_en    = q_pop && (q_op.kind == OP_APPEND) && (count < CW'(MAX_VERTICES));
  assign out_free = !result_valid || !result_stall;

  // store write and registered reads of both segment ends
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count[AW-1:0]] <= q_op.x;
      mem_y[count[AW-1:0]] <= q_op.y;
    end
    ax <= mem_x[idx_a];
    ay <= mem_y[idx_a];
    bx <= mem_x[idx_b];
    by <= mem_y[idx_b];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      D_M1:    begin mul_a = mag33(dx); mul_b = mag33(dx); end
      D_M2:    begin mul_a = mag33(dy); mul_b = mag33(dy); end
      D_IM:    begin mul_a = mag33(s_axis); mul_b = {1'b0, r}; end
      C_M1:    begin mul_a = mag33(wx); mul_b = mag33(dx); end
      C_M2:    begin mul_a = mag33(wy); mul_b = mag33(dy); end
      C_M3:    begin mul_a = mag33(dx); mul_b = mag33(dx); end
      C_M4:    begin mul_a = mag33(dy); mul_b = mag33(dy); end
      C_IM1:   begin mul_a = mag33(s_axis); mul_b = num[32:0]; end
      C_IM2:   begin mul_a = mag33(s_axis); mul_b = num[65:33]; end
      C_D1: begin
        mul_a = mag33({qx[31], qx} - {cur.x[31], cur.x});
        mul_b = mul_a;
      end
      C_D2: begin
        mul_a = mag33({qy[31], qy} - {cur.y[31], cur.y});
        mul_b = mul_a;
      end
      C_L0: begin
        mul_a = {25'd0, cfg.pick_radius_pixels};
        mul_b = {9'd0, cfg.map_units_per_pixel};
      end
      C_L1:    begin mul_a = prod[32:0]; mul_b = prod[32:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_sign = (state == C_M1) ? (wx[32] ^ dx[32]) : (wy[32] ^ dy[32]);

  // square root step: two radicand bits a cycle
  assign sq_t     = {sq_rem, acc[65:64]};
  assign sq_trial = {2'b00, root, 2'b01};

  // divider step: one quotient bit a cycle
  assign dv_den = (cur.kind == OP_DIST) ? {34'd0, root} : {1'b0, den};
  assign dv_t   = {acc[98:33], acc[32]};
  assign dv_ge  = dv_t >= dv_den;
  assign dv_rem = dv_ge ? 66'(dv_t - dv_den) : dv_t[65:0];

  // interpolated coordinate for the current axis
  assign s_axis    = axis ? dy : dx;
  assign base_axis = axis ? ay : ax;
  assign pt        = s_axis[32] ? (base_axis - acc[31:0]) : (base_axis + acc[31:0]);

  assign num_add = psign ? (67'd0 - {1'b0, prod}) : {1'b0, prod};
  assign d2      = acc[65:0] + prod;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_op.kind)
              OP_CLEAR:  count <= '0;
              OP_APPEND: if (wr_en) count <= count + 1'b1;
              default:   if (count != '0) state <= ST_LOOP;
            endcase
          end
        end
        ST_LOOP: begin
          if (i_plus1 < {1'b0, count}) begin
            state <= ST_DIFF;
          end else if (cur.kind == OP_DIST) begin
            state <= ST_LAST;
          end else begin
            state <= have ? C_L0 : ST_IDLE;
          end
        end
        ST_DIFF: state <= (cur.kind == OP_DIST) ? D_M1 : C_M1;
        ST_LAST: state <= ST_OUT;
        D_M1:    state <= D_M2;
        D_M2:    state <= D_M3;
        D_M3:    state <= D_SQ;
        D_SQ:    if (iter == '0) state <= D_CMP;
        D_CMP:   state <= ({1'b0, r} < root) ? D_IM : ST_LOOP;
        D_IM:    state <= D_DL;
        D_DL:    state <= DV;
        DV:      if (iter == '0) state <= DV_END;
        DV_END: begin
          if (!axis) begin
            state <= (cur.kind == OP_DIST) ? D_IM : C_IM1;
          end else begin
            state <= (cur.kind == OP_DIST) ? ST_OUT : C_D1;
          end
        end
        C_M1:    state <= C_M2;
        C_M2:    state <= C_M3;
        C_M3:    state <= C_M4;
        C_M4:    state <= C_M5;
        C_M5:    state <= C_CLS;
        C_CLS: begin
          if (num[66] || num == '0 || num[65:0] >= den) state <= C_D1;
          else state <= C_IM1;
        end
        C_IM1:   state <= C_IM2;
        C_IM2:   state <= C_IM3;
        C_IM3:   state <= DV;
        C_D1:    state <= C_D2;
        C_D2:    state <= C_D3;
        C_D3:    state <= ST_LOOP;
        C_L0:    state <= C_L1;
        C_L1:    state <= C_L2;
        C_L2:    state <= (best < prod) ? ST_OUT : ST_IDLE;
        ST_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        cur  <= q_op;
        i    <= '0;
        r    <= q_op.along;
        have <= 1'b0;
      end
      ST_DIFF: begin
        dx   <= {bx[31], bx} - {ax[31], ax};
        dy   <= {by[31], by} - {ay[31], ay};
        wx   <= {cur.x[31], cur.x} - {ax[31], ax};
        wy   <= {cur.y[31], cur.y} - {ay[31], ay};
        axis <= 1'b0;
      end
      ST_LAST: begin
        res <= '{reply_kind: REPLY_DIST, point_x: ax, point_y: ay, segment_index: 8'(i)};
      end
      D_M2: acc <= {33'd0, prod};
      D_M3: begin
        acc    <= {33'd0, acc[65:0] + prod};
        sq_rem <= '0;
        root   <= '0;
        iter   <= 6'd32;
      end
      D_SQ: begin
        if (sq_t >= sq_trial) begin
          sq_rem <= 35'(sq_t - sq_trial);
          root   <= {root[31:0], 1'b1};
        end else begin
          sq_rem <= sq_t[34:0];
          root   <= {root[31:0], 1'b0};
        end
        acc  <= {acc[96:0], 2'b00};
        iter <= iter - 1'b1;
      end
      D_CMP: begin
        if (!({1'b0, r} < root)) begin
          r <= r - root[31:0];
          i <= i + 1'b1;
        end
      end
      D_DL: begin
        acc  <= {33'd0, prod};
        iter <= 6'd32;
      end
      DV: begin
        acc  <= {dv_rem, acc[31:0], dv_ge};
        iter <= iter - 1'b1;
      end
      DV_END: begin
        if (!axis) begin
          qx   <= pt;
          axis <= 1'b1;
        end else begin
          qy  <= pt;
          res <= '{reply_kind: REPLY_DIST, point_x: qx, point_y: pt, segment_index: 8'(i)};
        end
      end
      C_M1: psign <= mul_sign;
      C_M2: begin
        num   <= num_add;
        psign <= mul_sign;
      end
      C_M3: num <= num + num_add;
      C_M4: den <= prod;
      C_M5: den <= den + prod;
      C_CLS: begin
        if (num[66] || num == '0) begin
          qx <= ax;
          qy <= ay;
        end else if (num[65:0] >= den) begin
          qx <= bx;
          qy <= by;
        end
      end
      C_IM2: acc <= {33'd0, prod};
      C_IM3: begin
        acc  <= acc + {prod, 33'd0};
        iter <= 6'd32;
      end
      C_D2: acc <= {33'd0, prod};
      C_D3: begin
        if (!have || d2 < best) begin
          have <= 1'b1;
          best <= d2;
          bqx  <= qx;
          bqy  <= qy;
          bi   <= i;
        end
        i <= i + 1'b1;
      end
      C_L2: begin
        res <= '{reply_kind: REPLY_NEAREST, point_x: bqx, point_y: bqy,
                 segment_index: 8'(bi)};
      end
      ST_OUT: if (out_free) result <= res;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/polyline_locate_point.sv */
// Polyline point locator: a polyline of up to MAX_VERTICES vertices is built
// by clear and append words; a distance query returns the point that far along
// the line (or the last vertex), a cursor query returns the nearest point on
// the line when it lies inside the pick radius. A query walks the segments one
// at a time through one shared 33x33 multiplier and a divider that resolves one
// quotient bit a cycle; a distance query also uses a square root that resolves
// one result bit a cycle. Words keep arriving into a two-entry queue while a
// query runs, and a finished result waits in its own register. Registers:
// map_units_per_pixel at byte address 0, pick_radius_pixels at byte address 4.
// Depends on plp_pkg, plp_front, plp_queue and plp_back.
`timescale 1ns / 1ps
`default_nettype none
module polyline_locate_point
  import plp_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic push, queue_full, q_pop, q_valid;
  op_t  push_op, q_op;
  logic cfg_write;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_RADIUS) ? {24'd0, cfg.pick_radius_pixels}
                                             : {8'd0, cfg.map_units_per_pixel};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_units_per_pixel <= MUPP_RESET;
      cfg.pick_radius_pixels  <= RADIUS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MUPP) cfg.map_units_per_pixel <= pwdata[23:0];
      else cfg.pick_radius_pixels <= pwdata[7:0];
    end
  end

  plp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  plp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_op)
  );

  plp_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
